FILE: src/table_2d_bilinear_interpolator_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the table interpolator modules.
// Each macro expands to one labelled concurrent assertion that is disabled
// while the synchronous, active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TABLE_2D_BILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define TABLE_2D_BILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge.
`define TBI_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TBI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define TBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tbi_pkg.sv
// ---------------------------------------------------------------------------
// tbi_pkg
// Types and constants shared by the two-dimensional table interpolator.
// ---------------------------------------------------------------------------
package tbi_pkg;

    localparam int DATA_W           = 32;
    localparam int FRAC_W           = 16;
    localparam int IDX_W            = 4;
    localparam int CNT_W            = 5;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int MAX_X_POINTS_DEF = 16;
    localparam int MAX_Y_POINTS_DEF = 16;
    localparam int FIFO_DEPTH       = 2;

    // Divider and multiplier widths of one linear step.
    localparam int DEN_W  = DATA_W + 1;
    localparam int NUM_W  = DEN_W + FRAC_W;
    localparam int MAG_W  = DATA_W + FRAC_W;
    localparam int PROD_W = DATA_W + DEN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;

    typedef enum logic [1:0] {
        CMD_WR_X  = 2'd0,
        CMD_WR_Y  = 2'd1,
        CMD_WR_Z  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          column_index;
        logic signed [DATA_W-1:0]  write_value;
        logic signed [DATA_W-1:0]  query_x;
        logic signed [DATA_W-1:0]  query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  interpolated_value;
        logic                      degenerate_error;
    } t_out_item;

    // One classified job between the front and the back end.
    typedef struct packed {
        t_cmd                      kind;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [DATA_W-1:0]  arg_a;
        logic signed [DATA_W-1:0]  arg_b;
    } t_job;

    typedef struct packed {
        logic                      start;
        logic signed [NUM_W-1:0]   num;
        logic signed [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0]  quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_REQ,
        ST_SRCH_CMP,
        ST_RD_X1,
        ST_RD_X2,
        ST_RD_Y1,
        ST_RD_Y2,
        ST_RD_ZA,
        ST_RD_ZB,
        ST_RD_ZC,
        ST_RD_ZD,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

FILE: src/tbi_front.sv
// ---------------------------------------------------------------------------
// tbi_front
// Accepts input beats, classifies them and drops writes aimed beyond the table.
// ---------------------------------------------------------------------------
module tbi_front #(
    parameter int MAX_X = tbi_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y = tbi_pkg::MAX_Y_POINTS_DEF
) (
    input  logic              i_push,
    input  tbi_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output tbi_pkg::t_job     o_job
);

    logic col_ok;
    logic row_ok;
    logic keep;

    always_comb begin
        col_ok = 32'(i_item.column_index) < MAX_X;
        row_ok = 32'(i_item.row_index) < MAX_Y;
        case (i_item.cmd)
            tbi_pkg::CMD_WR_X:  keep = col_ok;
            tbi_pkg::CMD_WR_Y:  keep = row_ok;
            tbi_pkg::CMD_WR_Z:  keep = col_ok && row_ok;
            default:            keep = 1'b1;
        endcase
    end

    always_comb begin
        o_job.kind = i_item.cmd;
        o_job.row  = i_item.row_index;
        o_job.col  = i_item.column_index;
        // A query carries its point, a write carries its value in the first slot.
        if (i_item.cmd == tbi_pkg::CMD_QUERY) begin
            o_job.arg_a = i_item.query_x;
        end else begin
            o_job.arg_a = i_item.write_value;
        end
        o_job.arg_b = i_item.query_y;
    end

    assign o_q_push = i_push && !i_q_full && keep;

endmodule

FILE: src/tbi_fifo.sv
// ---------------------------------------------------------------------------
// tbi_fifo
// Short job queue between the front and the back end.
// ---------------------------------------------------------------------------
`include "table_2d_bilinear_interpolator_unit_defines.svh"

module tbi_fifo #(
    parameter int DEPTH = tbi_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbi_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tbi_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tbi_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `TBI_ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "job queue overfilled")
    `TBI_ASSERT_NEXT(a_fifo_grow, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + CW'(1), "job queue lost a push")

endmodule

FILE: src/tbi_div.sv
// ---------------------------------------------------------------------------
// tbi_div
// Iterative signed divider, one quotient bit a cycle, truncating toward zero
// and saturating the quotient to 32 bits.
// ---------------------------------------------------------------------------
`include "table_2d_bilinear_interpolator_unit_defines.svh"

module tbi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbi_pkg::t_div_req i_req,
    output tbi_pkg::t_div_rsp o_rsp
);

    localparam int MW = tbi_pkg::MAG_W;
    localparam int DW = tbi_pkg::DEN_W;
    localparam int QW = tbi_pkg::DATA_W;
    localparam int KW = $clog2(MW + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [KW-1:0]     r_cnt;
    logic [MW-1:0]     r_n;
    logic [DW-1:0]     r_d;
    logic [DW-1:0]     r_rem;
    logic [DW:0]       trial;
    logic              qbit;
    logic [DW:0]       diff;
    logic signed [tbi_pkg::NUM_W-1:0] num_abs;
    logic signed [DW-1:0]             den_abs;

    always_comb begin
        num_abs = i_req.num[tbi_pkg::NUM_W-1] ? -i_req.num : i_req.num;
        den_abs = i_req.den[DW-1] ? -i_req.den : i_req.den;
        trial   = {r_rem, r_n[MW-1]};
        diff    = trial - {1'b0, r_d};
        qbit    = trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[tbi_pkg::NUM_W-1] ^ i_req.den[DW-1];
            r_n   <= MW'(num_abs);
            r_d   <= den_abs;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
            r_n   <= {r_n[MW-2:0], qbit};
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (!r_neg) begin
            o_rsp.quo = (|r_n[MW-1:QW-1]) ? {1'b0, {(QW-1){1'b1}}} : r_n[QW-1:0];
        end else if ((|r_n[MW-1:QW]) || (r_n[QW-1] && (|r_n[QW-2:0]))) begin
            o_rsp.quo = {1'b1, {(QW-1){1'b0}}};
        end else begin
            o_rsp.quo = -r_n[QW-1:0];
        end
    end

    `TBI_ASSERT_IMPLY(a_div_count, i_clk, i_rst_n, r_busy, r_cnt != '0, "divider running with no steps left")
    `TBI_ASSERT_NEXT(a_div_finish, i_clk, i_rst_n, r_busy && r_cnt == KW'(1) && !i_req.start, r_done && !r_busy, "divider missed its finish")

endmodule

FILE: src/tbi_back.sv
// ---------------------------------------------------------------------------
// tbi_back
// Carries out jobs: table writes, bracket searches, the three linear steps
// and the result register.
// ---------------------------------------------------------------------------
`include "table_2d_bilinear_interpolator_unit_defines.svh"

module tbi_back #(
    parameter int MAX_X = tbi_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y = tbi_pkg::MAX_Y_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  tbi_pkg::t_job                i_job,
    output logic                         o_job_pop,
    input  logic [tbi_pkg::CNT_W-1:0]    i_x_points,
    input  logic [tbi_pkg::CNT_W-1:0]    i_y_points,
    input  logic                         i_pop,
    output logic                         o_empty,
    output tbi_pkg::t_out_item           o_item
);

    localparam int DW  = tbi_pkg::DATA_W;
    localparam int PW  = tbi_pkg::PROD_W;
    localparam int FW  = tbi_pkg::FRAC_W;
    localparam int AWX = $clog2(MAX_X);
    localparam int AWY = $clog2(MAX_Y);
    localparam int SW  = (AWX > AWY) ? AWX : AWY;
    localparam int ZW  = $clog2(MAX_X * MAX_Y);
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    tbi_pkg::t_state r_state;
    tbi_pkg::t_state n_state;

    logic signed [DW-1:0] r_xmem [MAX_X];
    logic signed [DW-1:0] r_ymem [MAX_Y];
    logic signed [DW-1:0] r_zmem [MAX_X*MAX_Y];
    logic signed [DW-1:0] r_xrd;
    logic signed [DW-1:0] r_yrd;
    logic signed [DW-1:0] r_zrd;
    logic [AWX-1:0]       x_addr;
    logic [AWY-1:0]       y_addr;
    logic [ZW-1:0]        z_addr;

    logic [AWX-1:0] nx_m1;
    logic [AWY-1:0] ny_m1;
    logic           r_axis;
    logic [SW-1:0]  r_lo;
    logic [SW-1:0]  r_hi;
    logic [SW-1:0]  mid;
    logic [SW:0]    lo_hi_sum;
    logic           srch_done;
    logic           probe_gt;
    logic [AWX-1:0] r_xl;
    logic [AWX-1:0] r_xh;
    logic [AWY-1:0] r_yl;
    logic [AWY-1:0] r_yh;

    logic signed [DW-1:0] r_qx;
    logic signed [DW-1:0] r_qy;
    logic signed [DW-1:0] r_x1;
    logic signed [DW-1:0] r_x2;
    logic signed [DW-1:0] r_y1;
    logic signed [DW-1:0] r_y2;
    logic signed [DW-1:0] r_zll;
    logic signed [DW-1:0] r_zhl;
    logic signed [DW-1:0] r_zlh;
    logic signed [DW-1:0] r_zhh;
    logic signed [DW-1:0] r_f1;
    logic signed [DW-1:0] r_f2;
    logic signed [DW-1:0] r_ratio;
    logic signed [PW-1:0] r_prod;
    logic [1:0]           r_step;
    logic                 degenerate;

    logic signed [DW-1:0]         sel_p;
    logic signed [DW-1:0]         sel_a1;
    logic signed [DW-1:0]         sel_a2;
    logic signed [DW-1:0]         sel_v1;
    logic signed [DW-1:0]         sel_v2;
    logic signed [DW:0]           p_off;
    logic signed [DW:0]           dv;
    logic signed [PW-1:0]         term;
    logic signed [PW-1:0]         sum;
    logic signed [DW-1:0]         step_res;

    tbi_pkg::t_div_req  div_req;
    tbi_pkg::t_div_rsp  div_rsp;

    logic               r_out_valid;
    tbi_pkg::t_out_item r_out;
    logic               out_load;
    logic               wr_x;
    logic               wr_y;
    logic               wr_z;

    tbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Point counts clamped to between two and the table size, less one.
    always_comb begin
        if (i_x_points < tbi_pkg::CNT_W'(2)) begin
            nx_m1 = AWX'(1);
        end else if (32'(i_x_points) > MAX_X) begin
            nx_m1 = AWX'(MAX_X - 1);
        end else begin
            nx_m1 = AWX'(i_x_points - tbi_pkg::CNT_W'(1));
        end
        if (i_y_points < tbi_pkg::CNT_W'(2)) begin
            ny_m1 = AWY'(1);
        end else if (32'(i_y_points) > MAX_Y) begin
            ny_m1 = AWY'(MAX_Y - 1);
        end else begin
            ny_m1 = AWY'(i_y_points - tbi_pkg::CNT_W'(1));
        end
    end

    always_comb begin
        lo_hi_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        mid        = lo_hi_sum[SW:1];
        srch_done  = (r_hi - r_lo) == SW'(1);
        probe_gt   = r_axis ? (r_yrd > r_qy) : (r_xrd > r_qx);
        degenerate = (r_x1 == r_x2) || (r_y1 == r_y2);
    end

    // Operands of the current linear step.
    always_comb begin
        if (r_step == 2'd2) begin
            sel_p  = r_qx;
            sel_a1 = r_x1;
            sel_a2 = r_x2;
            sel_v1 = r_f1;
            sel_v2 = r_f2;
        end else if (r_step == 2'd1) begin
            sel_p  = r_qy;
            sel_a1 = r_y1;
            sel_a2 = r_y2;
            sel_v1 = r_zlh;
            sel_v2 = r_zhh;
        end else begin
            sel_p  = r_qy;
            sel_a1 = r_y1;
            sel_a2 = r_y2;
            sel_v1 = r_zll;
            sel_v2 = r_zhl;
        end
        p_off = {sel_p[DW-1], sel_p} - {sel_a1[DW-1], sel_a1};
        dv    = {sel_v2[DW-1], sel_v2} - {sel_v1[DW-1], sel_v1};
        term  = r_prod >>> FW;
        if (r_prod[PW-1] && (|r_prod[FW-1:0])) begin
            term = term + PW'(1);
        end
        sum = {{(PW-DW){sel_v1[DW-1]}}, sel_v1} + term;
        if (sum > SAT_HI) begin
            step_res = SAT_HI[DW-1:0];
        end else if (sum < SAT_LO) begin
            step_res = SAT_LO[DW-1:0];
        end else begin
            step_res = sum[DW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbi_pkg::ST_IDLE: begin
                if (i_job_valid && i_job.kind == tbi_pkg::CMD_QUERY) begin
                    n_state = tbi_pkg::ST_SRCH_REQ;
                end
            end
            tbi_pkg::ST_SRCH_REQ: begin
                if (!srch_done) begin
                    n_state = tbi_pkg::ST_SRCH_CMP;
                end else if (r_axis) begin
                    n_state = tbi_pkg::ST_RD_X1;
                end
            end
            tbi_pkg::ST_SRCH_CMP: n_state = tbi_pkg::ST_SRCH_REQ;
            tbi_pkg::ST_RD_X1:    n_state = tbi_pkg::ST_RD_X2;
            tbi_pkg::ST_RD_X2:    n_state = tbi_pkg::ST_RD_Y1;
            tbi_pkg::ST_RD_Y1:    n_state = tbi_pkg::ST_RD_Y2;
            tbi_pkg::ST_RD_Y2:    n_state = tbi_pkg::ST_RD_ZA;
            tbi_pkg::ST_RD_ZA:    n_state = tbi_pkg::ST_RD_ZB;
            tbi_pkg::ST_RD_ZB:    n_state = tbi_pkg::ST_RD_ZC;
            tbi_pkg::ST_RD_ZC:    n_state = tbi_pkg::ST_RD_ZD;
            tbi_pkg::ST_RD_ZD:    n_state = tbi_pkg::ST_CHECK;
            tbi_pkg::ST_CHECK: begin
                n_state = degenerate ? tbi_pkg::ST_OUT : tbi_pkg::ST_DIV_GO;
            end
            tbi_pkg::ST_DIV_GO:   n_state = tbi_pkg::ST_DIV_WAIT;
            tbi_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = tbi_pkg::ST_MUL;
                end
            end
            tbi_pkg::ST_MUL:      n_state = tbi_pkg::ST_ADD;
            tbi_pkg::ST_ADD: begin
                case (r_step)
                    2'd0:    n_state = tbi_pkg::ST_MUL;
                    2'd1:    n_state = tbi_pkg::ST_DIV_GO;
                    default: n_state = tbi_pkg::ST_OUT;
                endcase
            end
            tbi_pkg::ST_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_state = tbi_pkg::ST_IDLE;
                end
            end
            default:              n_state = tbi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop     = 1'b0;
        wr_x          = 1'b0;
        wr_y          = 1'b0;
        wr_z          = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = {p_off, {FW{1'b0}}};
        div_req.den   = {sel_a2[DW-1], sel_a2} - {sel_a1[DW-1], sel_a1};
        x_addr        = AWX'(mid);
        y_addr        = AWY'(mid);
        z_addr        = ZW'(32'(r_yl) * MAX_X + 32'(r_xl));
        case (r_state)
            tbi_pkg::ST_IDLE: begin
                o_job_pop = i_job_valid;
                wr_x      = i_job_valid && i_job.kind == tbi_pkg::CMD_WR_X;
                wr_y      = i_job_valid && i_job.kind == tbi_pkg::CMD_WR_Y;
                wr_z      = i_job_valid && i_job.kind == tbi_pkg::CMD_WR_Z;
                z_addr    = ZW'(32'(i_job.row) * MAX_X + 32'(i_job.col));
            end
            tbi_pkg::ST_RD_X1: x_addr = r_xl;
            tbi_pkg::ST_RD_X2: x_addr = r_xh;
            tbi_pkg::ST_RD_Y1: y_addr = r_yl;
            tbi_pkg::ST_RD_Y2: y_addr = r_yh;
            tbi_pkg::ST_RD_ZB: z_addr = ZW'(32'(r_yh) * MAX_X + 32'(r_xl));
            tbi_pkg::ST_RD_ZC: z_addr = ZW'(32'(r_yl) * MAX_X + 32'(r_xh));
            tbi_pkg::ST_RD_ZD: z_addr = ZW'(32'(r_yh) * MAX_X + 32'(r_xh));
            tbi_pkg::ST_DIV_GO: div_req.start = 1'b1;
            tbi_pkg::ST_OUT:   out_load = !r_out_valid || i_pop;
            default: begin
            end
        endcase
    end

    // Table storage: one write port, registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_x) begin
            r_xmem[AWX'(i_job.col)] <= i_job.arg_a;
        end
        if (wr_y) begin
            r_ymem[AWY'(i_job.row)] <= i_job.arg_a;
        end
        if (wr_z) begin
            r_zmem[z_addr] <= i_job.arg_a;
        end
        r_xrd <= r_xmem[x_addr];
        r_yrd <= r_ymem[y_addr];
        r_zrd <= r_zmem[z_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbi_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tbi_pkg::ST_IDLE: begin
                r_qx   <= i_job.arg_a;
                r_qy   <= i_job.arg_b;
                r_axis <= 1'b0;
                r_lo   <= '0;
                r_hi   <= SW'(nx_m1);
                r_step <= 2'd0;
            end
            tbi_pkg::ST_SRCH_REQ: begin
                if (srch_done && !r_axis) begin
                    r_xl   <= AWX'(r_lo);
                    r_xh   <= AWX'(r_hi);
                    r_axis <= 1'b1;
                    r_lo   <= '0;
                    r_hi   <= SW'(ny_m1);
                end else if (srch_done) begin
                    r_yl <= AWY'(r_lo);
                    r_yh <= AWY'(r_hi);
                end
            end
            tbi_pkg::ST_SRCH_CMP: begin
                if (probe_gt) begin
                    r_hi <= mid;
                end else begin
                    r_lo <= mid;
                end
            end
            tbi_pkg::ST_RD_X2: r_x1  <= r_xrd;
            tbi_pkg::ST_RD_Y1: r_x2  <= r_xrd;
            tbi_pkg::ST_RD_Y2: r_y1  <= r_yrd;
            tbi_pkg::ST_RD_ZA: r_y2  <= r_yrd;
            tbi_pkg::ST_RD_ZB: r_zll <= r_zrd;
            tbi_pkg::ST_RD_ZC: r_zhl <= r_zrd;
            tbi_pkg::ST_RD_ZD: r_zlh <= r_zrd;
            tbi_pkg::ST_CHECK: r_zhh <= r_zrd;
            tbi_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_ratio <= div_rsp.quo;
                end
            end
            tbi_pkg::ST_MUL: r_prod <= r_ratio * dv;
            tbi_pkg::ST_ADD: begin
                case (r_step)
                    2'd1:    r_f2 <= step_res;
                    default: r_f1 <= step_res;
                endcase
                r_step <= r_step + 2'd1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.degenerate_error   <= degenerate;
            r_out.interpolated_value <= degenerate ? '0 : r_f1;
        end
    end

    // The final step leaves its result in r_f1 so that the output load reads one place.
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    `TBI_ASSERT_IMPLY(a_deg_zero, i_clk, i_rst_n, r_out_valid && r_out.degenerate_error, r_out.interpolated_value == '0, "degenerate result not zero")
    `TBI_ASSERT_IMPLY(a_div_state, i_clk, i_rst_n, div_rsp.done, r_state == tbi_pkg::ST_DIV_WAIT, "quotient arrived outside the wait state")
    `TBI_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, r_out_valid && r_state == tbi_pkg::ST_IDLE, "result beat not held after load")

endmodule

FILE: src/table_2d_bilinear_interpolator_unit.sv
// ---------------------------------------------------------------------------
// table_2d_bilinear_interpolator_unit
// Two-dimensional lookup table with bilinear interpolation in signed Q16.16.
//
// Input is a queue: a beat is taken when i_push is high and o_full is low.
// Write beats load an x or y breakpoint or a z grid entry and give no result;
// a query beat gives exactly one result beat. Results form a queue too: the
// oldest result sits on o_item while o_empty is low and leaves when i_pop is
// high. Configuration beats (point counts) are taken on any edge with
// i_cfg_valid high, as o_cfg_ready is always high.
// A write is carried out in the same cycle as it leaves the two-entry job queue.
// A query runs two bracket searches, which step one memory read at a time,
// and the shared divider computes each of the two ratios that it needs.
// The job queue keeps taking beats while a query runs or a result waits; when
// the receiver stalls the back end holds its next result until o_item frees.
// Reset clears the queues and sets both point counts to two; table contents
// stay undefined until written.
// ---------------------------------------------------------------------------
module table_2d_bilinear_interpolator_unit #(
    parameter int MAX_X_POINTS = tbi_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y_POINTS = tbi_pkg::MAX_Y_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  tbi_pkg::t_in_item                 i_item,
    output logic                              o_empty,
    input  logic                              i_pop,
    output tbi_pkg::t_out_item                o_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [tbi_pkg::CNT_W-1:0] r_x_points;
    logic [tbi_pkg::CNT_W-1:0] r_y_points;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    tbi_pkg::t_job             front_job;
    tbi_pkg::t_job             back_job;

    // Point count registers; an index past the list is simply dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_points <= tbi_pkg::CNT_W'(2);
            r_y_points <= tbi_pkg::CNT_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbi_pkg::CFG_X_POINTS: r_x_points <= i_cfg_data[tbi_pkg::CNT_W-1:0];
                tbi_pkg::CFG_Y_POINTS: r_y_points <= i_cfg_data[tbi_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies each beat; out-of-range writes never reach the queue.
    tbi_front #(
        .MAX_X (MAX_X_POINTS),
        .MAX_Y (MAX_Y_POINTS)
    ) u_front (
        .i_push   (i_push),
        .i_item   (i_item),
        .i_q_full (o_full),
        .o_q_push (q_push),
        .o_job    (front_job)
    );

    tbi_fifo #(
        .DEPTH (tbi_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    // The back end owns the tables, the searches, the arithmetic and the result beat.
    tbi_back #(
        .MAX_X (MAX_X_POINTS),
        .MAX_Y (MAX_Y_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_job_pop   (q_pop),
        .i_x_points  (r_x_points),
        .i_y_points  (r_y_points),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_item      (o_item)
    );

endmodule
